/* rtl/rofs_pkg.sv */
// ----------------------------------------------------------------------------
// rofs_pkg
// Shared types and constants for the ring of sized entries with byte-offset
// lookup: word layouts of both channels, the mode codes and default sizes.
// ----------------------------------------------------------------------------
package rofs_pkg;

    // default sizes for the top level parameters
    localparam int SLOTS_DEF        = 16;
    localparam int HANDLE_WIDTH_DEF = 32;
    localparam int SIZE_WIDTH_DEF   = 16;

    // fixed field widths of the channel words
    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 16;
    localparam int OFFSET_W = 20;
    localparam int SLOT_W   = 4;

    // item modes
    typedef enum logic {
        MODE_ADD  = 1'b0,
        MODE_FIND = 1'b1
    } mode_t;

    // input word
    typedef struct packed {
        mode_t                 mode;
        logic [HANDLE_W-1:0]   entry_handle;
        logic [SIZE_W-1:0]     entry_size;
        logic [OFFSET_W-1:0]   stream_offset;
    } in_t;

    // result word
    typedef struct packed {
        logic                  found;
        logic [SLOT_W-1:0]     slot;
        logic [HANDLE_W-1:0]   found_handle;
        logic [SIZE_W-1:0]     byte_offset;
    } out_t;

endpackage

/* rtl/rofs_ring_mem.sv */
// ----------------------------------------------------------------------------
// rofs_ring_mem
// Entry store of the ring: one write port, one read port with registered
// data. Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module rofs_ring_mem #(
    parameter int SLOTS        = rofs_pkg::SLOTS_DEF,
    parameter int HANDLE_WIDTH = rofs_pkg::HANDLE_WIDTH_DEF,
    parameter int SIZE_WIDTH   = rofs_pkg::SIZE_WIDTH_DEF,
    localparam int PTR_W       = $clog2(SLOTS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [PTR_W-1:0]        wr_addr,
    input  logic [HANDLE_WIDTH-1:0] wr_handle,
    input  logic [SIZE_WIDTH-1:0]   wr_size,
    input  logic                    rd_en,
    input  logic [PTR_W-1:0]        rd_addr,
    output logic [HANDLE_WIDTH-1:0] rd_handle,
    output logic [SIZE_WIDTH-1:0]   rd_size
);

    logic [HANDLE_WIDTH-1:0] handle_mem [SLOTS];
    logic [SIZE_WIDTH-1:0]   size_mem   [SLOTS];
    logic [SLOTS-1:0]        valid_reg;
    logic [HANDLE_WIDTH-1:0] rd_handle_reg;
    logic [SIZE_WIDTH-1:0]   rd_size_reg;

    // storage write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            handle_mem[wr_addr] <= wr_handle;
            size_mem[wr_addr]   <= wr_size;
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // registered read, unwritten entries read as zero
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (valid_reg[rd_addr])
            begin
                rd_handle_reg <= handle_mem[rd_addr];
                rd_size_reg   <= size_mem[rd_addr];
            end
            else
            begin
                rd_handle_reg <= '0;
                rd_size_reg   <= '0;
            end
        end
    end

    assign rd_handle = rd_handle_reg;
    assign rd_size   = rd_size_reg;

endmodule

/* rtl/rofs_walk_ctrl.sv */
// ----------------------------------------------------------------------------
// rofs_walk_ctrl
// Ring pointers and the find walk. Adds write the store at the write
// position; finds stream reads from the read position one slot per cycle
// and check each returned entry in the cycle after its read.
// ----------------------------------------------------------------------------
module rofs_walk_ctrl #(
    parameter int SLOTS        = rofs_pkg::SLOTS_DEF,
    parameter int HANDLE_WIDTH = rofs_pkg::HANDLE_WIDTH_DEF,
    parameter int SIZE_WIDTH   = rofs_pkg::SIZE_WIDTH_DEF,
    localparam int PTR_W       = $clog2(SLOTS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  rofs_pkg::in_t           item,
    output logic                    done,
    output rofs_pkg::out_t          result,
    output logic                    wr_en,
    output logic [PTR_W-1:0]        wr_addr,
    output logic [HANDLE_WIDTH-1:0] wr_handle,
    output logic [SIZE_WIDTH-1:0]   wr_size,
    output logic                    rd_en,
    output logic [PTR_W-1:0]        rd_addr,
    input  logic [HANDLE_WIDTH-1:0] rd_handle,
    input  logic [SIZE_WIDTH-1:0]   rd_size
);

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (SIZE_WIDTH > rofs_pkg::OFFSET_W) ? SIZE_WIDTH
                                                             : rofs_pkg::OFFSET_W;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t                      state_reg, state_next;
    logic [PTR_W-1:0]            wpos_reg, wpos_next;
    logic [PTR_W-1:0]            rpos_reg, rpos_next;
    logic                        full_reg, full_next;
    logic [PTR_W-1:0]            addr_reg, addr_next;
    logic [PTR_W-1:0]            eaddr_reg, eaddr_next;
    logic [CNT_W-1:0]            iss_cnt_reg, iss_cnt_next;
    logic [PTR_W-1:0]            ev_cnt_reg, ev_cnt_next;
    logic                        pend_reg, pend_next;
    logic [rofs_pkg::OFFSET_W-1:0] rem_reg, rem_next;
    logic                        done_reg, done_next;
    rofs_pkg::out_t              res_reg, res_next;

    logic [CMP_W-1:0]            rem_ext;
    logic [CMP_W-1:0]            size_ext;

    assign rem_ext  = CMP_W'(rem_reg);
    assign size_ext = CMP_W'(rd_size);

    // write port straight from the accepted word
    assign wr_addr   = wpos_reg;
    assign wr_handle = HANDLE_WIDTH'(item.entry_handle);
    assign wr_size   = SIZE_WIDTH'(item.entry_size);
    assign rd_addr   = addr_reg;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // pointer update and walk sequencing
    always_comb
    begin
        state_next   = state_reg;
        wpos_next    = wpos_reg;
        rpos_next    = rpos_reg;
        full_next    = full_reg;
        addr_next    = addr_reg;
        eaddr_next   = eaddr_reg;
        iss_cnt_next = iss_cnt_reg;
        ev_cnt_next  = ev_cnt_reg;
        pend_next    = pend_reg;
        rem_next     = rem_reg;
        done_next    = 1'b0;
        res_next     = res_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (item.mode == rofs_pkg::MODE_ADD)
                    begin
                        wr_en     = 1'b1;
                        wpos_next = (wpos_reg == LAST_SLOT) ? '0 : wpos_reg + 1'b1;
                        if (full_reg)
                        begin
                            rpos_next = (rpos_reg == LAST_SLOT) ? '0 : rpos_reg + 1'b1;
                        end
                        if (wpos_reg == LAST_SLOT)
                        begin
                            full_next = 1'b1;
                        end
                        done_next = 1'b1;
                        res_next  = '0;
                    end
                    else
                    begin
                        state_next   = ST_WALK;
                        addr_next    = rpos_reg;
                        iss_cnt_next = '0;
                        ev_cnt_next  = '0;
                        pend_next    = 1'b0;
                        rem_next     = item.stream_offset;
                    end
                end
            end

            ST_WALK:
            begin
                // issue side: one read a cycle, at most one per slot
                rd_en = (iss_cnt_reg != CNT_W'(SLOTS));
                if (rd_en)
                begin
                    addr_next    = (addr_reg == LAST_SLOT) ? '0 : addr_reg + 1'b1;
                    iss_cnt_next = iss_cnt_reg + 1'b1;
                    eaddr_next   = addr_reg;
                end
                pend_next = rd_en;

                // check side: entry returned for the previous read
                if (pend_reg)
                begin
                    if (rd_size == '0)
                    begin
                        state_next = ST_IDLE;
                        pend_next  = 1'b0;
                        done_next  = 1'b1;
                        res_next   = '0;
                    end
                    else if (rem_ext < size_ext)
                    begin
                        state_next            = ST_IDLE;
                        pend_next             = 1'b0;
                        done_next             = 1'b1;
                        res_next.found        = 1'b1;
                        res_next.slot         = rofs_pkg::SLOT_W'(eaddr_reg);
                        res_next.found_handle = rofs_pkg::HANDLE_W'(rd_handle);
                        res_next.byte_offset  = rem_reg[rofs_pkg::SIZE_W-1:0];
                    end
                    else
                    begin
                        rem_next    = rofs_pkg::OFFSET_W'(rem_ext - size_ext);
                        ev_cnt_next = ev_cnt_reg + 1'b1;
                        if (ev_cnt_reg == LAST_SLOT)
                        begin
                            state_next = ST_IDLE;
                            pend_next  = 1'b0;
                            done_next  = 1'b1;
                            res_next   = '0;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wpos_reg    <= '0;
            rpos_reg    <= '0;
            full_reg    <= 1'b0;
            iss_cnt_reg <= '0;
            ev_cnt_reg  <= '0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wpos_reg    <= wpos_next;
            rpos_reg    <= rpos_next;
            full_reg    <= full_next;
            iss_cnt_reg <= iss_cnt_next;
            ev_cnt_reg  <= ev_cnt_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
        end
    end

    // walk payload registers
    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        eaddr_reg <= eaddr_next;
        rem_reg   <= rem_next;
        res_reg   <= res_next;
    end

`ifndef SYNTHESIS
    // a result word only appears once the walk has released the store
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while walk still active");

    // no read data left in flight once idle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(pend_reg && (state_reg == ST_IDLE)))
        else $error("read pending outside a walk");

    // the read position only moves after the ring has filled once
    assert property (@(posedge clk) disable iff (!rst_n)
        !full_reg |-> (rpos_reg == '0))
        else $error("read position moved before ring full");

    // a walk never issues more reads than there are slots
    assert property (@(posedge clk) disable iff (!rst_n)
        iss_cnt_reg <= CNT_W'(SLOTS))
        else $error("walk issued too many reads");

    // an add leaves the block ready and strobes its word on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.mode == rofs_pkg::MODE_ADD)) |=> (done_reg && !busy))
        else $error("add did not complete in one cycle");
`endif

endmodule

/* rtl/ring_of_sized_entries_offset_lookup_top.sv */
// ----------------------------------------------------------------------------
// ring_of_sized_entries_offset_lookup_top
// Ring of sized entries with byte-offset lookup, built around a single-port
// read / single-port write entry store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive item and raise start; the word is taken at a rising
//   edge with start high and busy low. item.mode selects add or find.
//   Result channel: every accepted word yields one result word on result,
//   valid for exactly one cycle while done is high. The receiver cannot
//   stall, so it must take the word in that cycle.
//   Add: written into the store at the accept edge; done follows in the
//   next cycle and busy stays low, so adds can go in every cycle.
//   Find: busy stays high while the walk looks at entries, 1 to SLOTS of
//   them; done comes with busy falling.
//   The walk is paced by the store's one read port: one entry per cycle,
//   with the registered read at the start of the walk.
//   Busy holds off new words while a walk reads the store, so adds never
//   overlap a find.
//   Reset (rst_n low, asynchronous) empties the ring: all entries read as
//   zero, pointers and full flag clear. No clearing pass is needed.
// ----------------------------------------------------------------------------
module ring_of_sized_entries_offset_lookup_top #(
    parameter int SLOTS        = rofs_pkg::SLOTS_DEF,
    parameter int HANDLE_WIDTH = rofs_pkg::HANDLE_WIDTH_DEF,
    parameter int SIZE_WIDTH   = rofs_pkg::SIZE_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rofs_pkg::in_t  item,
    output logic           done,
    output rofs_pkg::out_t result
);

    localparam int PTR_W = $clog2(SLOTS);

    logic                    wr_en;
    logic [PTR_W-1:0]        wr_addr;
    logic [HANDLE_WIDTH-1:0] wr_handle;
    logic [SIZE_WIDTH-1:0]   wr_size;
    logic                    rd_en;
    logic [PTR_W-1:0]        rd_addr;
    logic [HANDLE_WIDTH-1:0] rd_handle;
    logic [SIZE_WIDTH-1:0]   rd_size;

    // pointers and walk sequencer
    rofs_walk_ctrl #(
        .SLOTS        (SLOTS),
        .HANDLE_WIDTH (HANDLE_WIDTH),
        .SIZE_WIDTH   (SIZE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_handle (wr_handle),
        .wr_size   (wr_size),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_handle (rd_handle),
        .rd_size   (rd_size)
    );

    // entry store
    rofs_ring_mem #(
        .SLOTS        (SLOTS),
        .HANDLE_WIDTH (HANDLE_WIDTH),
        .SIZE_WIDTH   (SIZE_WIDTH)
    ) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_handle (wr_handle),
        .wr_size   (wr_size),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_handle (rd_handle),
        .rd_size   (rd_size)
    );

endmodule
